// ===== src/rpe_pkg.sv =====
// Shared constants and types for the rotary position embedding block.
`default_nettype none

package rpe_pkg;

    // Parameter defaults
    localparam int DEF_MAX_HALF_DIM = 64;
    localparam int DEF_SAMPLE_BITS  = 16;

    // Fixed field widths
    localparam int COEF_W     = 16;
    localparam int FRAC_BITS  = COEF_W - 1;
    localparam int PAIR_IDX_W = 6;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Register indexes
    localparam t_cfg_idx REG_MODE_INTERLEAVED = 1'd0;
    localparam t_cfg_idx REG_HALF_DIM         = 1'd1;

    localparam logic [CFG_W-1:0] HALF_DIM_RESET = 7'd64;

    // Control travelling with a pair from the front end to the rotator
    typedef struct packed {
        logic [PAIR_IDX_W-1:0] pair_index;
        logic                  row_done;
        logic                  use_mem;
    } t_pair_ctl;

endpackage

`default_nettype wire

// ===== src/rpe_in_if.sv =====
// Input channel: one row element with its cosine and sine.
`default_nettype none

interface rpe_in_if #(
    parameter int SAMPLE_BITS = rpe_pkg::DEF_SAMPLE_BITS
);
    logic                                valid;
    logic                                ready;
    logic signed [SAMPLE_BITS-1:0]       x_value;
    logic signed [rpe_pkg::COEF_W-1:0]   cos_value;
    logic signed [rpe_pkg::COEF_W-1:0]   sin_value;

    modport source (output valid, output x_value, output cos_value, output sin_value,
                    input ready);
    modport sink   (input valid, input x_value, input cos_value, input sin_value,
                    output ready);
endinterface

`default_nettype wire

// ===== src/rpe_out_if.sv =====
// Output channel: one rotated pair with its position in the row.
`default_nettype none

interface rpe_out_if #(
    parameter int SAMPLE_BITS = rpe_pkg::DEF_SAMPLE_BITS
);
    logic                                valid;
    logic                                ready;
    logic signed [SAMPLE_BITS-1:0]       y_first;
    logic signed [SAMPLE_BITS-1:0]       y_second;
    logic [rpe_pkg::PAIR_IDX_W-1:0]      pair_index;
    logic                                row_done;

    modport source (output valid, output y_first, output y_second, output pair_index,
                    output row_done, input ready);
    modport sink   (input valid, input y_first, input y_second, input pair_index,
                    input row_done, output ready);
endinterface

`default_nettype wire

// ===== src/rpe_front.sv =====
// Element counter, pair former and first-half store with its read stage.
`default_nettype none

module rpe_front #(
    parameter int MAX_HALF_DIM = rpe_pkg::DEF_MAX_HALF_DIM,
    parameter int SAMPLE_BITS  = rpe_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_mode_interleaved,
    input  wire logic [rpe_pkg::CFG_W-1:0]         i_half_dim,
    input  wire logic                              i_restart,
    rpe_in_if.sink                                 i_in,
    input  wire logic                              i_rdy1,
    output logic                                   o_v1,
    output rpe_pkg::t_pair_ctl                     o_ctl,
    output logic signed [SAMPLE_BITS-1:0]          o_x0,
    output logic signed [SAMPLE_BITS-1:0]          o_x1,
    output logic signed [rpe_pkg::COEF_W-1:0]      o_cos,
    output logic signed [rpe_pkg::COEF_W-1:0]      o_sin
);
    import rpe_pkg::*;

    localparam int CNT_W = $clog2(2 * MAX_HALF_DIM + 1);
    localparam int AW    = (MAX_HALF_DIM > 1) ? $clog2(MAX_HALF_DIM) : 1;
    localparam int EW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int MW    = SAMPLE_BITS + 2 * COEF_W;

    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] eff_half;
    logic [EW-1:0]    hd_ext;
    logic [CNT_W:0]   row_len;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] pair_j;
    logic             is_result;
    logic             row_end;
    logic             accept;
    logic             wr_en;
    logic             rd_en;

    logic signed [SAMPLE_BITS-1:0] r_pending_x;

    logic [MW-1:0]    r_mem [MAX_HALF_DIM];
    logic [MW-1:0]    r_mem_q;

    logic                          r_v1;
    t_pair_ctl                     r_ctl1;
    logic signed [SAMPLE_BITS-1:0] r_x0;
    logic signed [SAMPLE_BITS-1:0] r_x1;
    logic signed [COEF_W-1:0]      r_cos;
    logic signed [COEF_W-1:0]      r_sin;

    assign i_in.ready = !r_v1 || i_rdy1;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        hd_ext = EW'(i_half_dim);
        if (i_half_dim == '0) begin
            eff_half = CNT_W'(1);
        end else if (hd_ext > EW'(MAX_HALF_DIM)) begin
            eff_half = CNT_W'(MAX_HALF_DIM);
        end else begin
            eff_half = hd_ext[CNT_W-1:0];
        end
        row_len = {eff_half, 1'b0};
        // Treat a count beyond the row as its start
        pos = ({1'b0, r_count} >= row_len) ? '0 : r_count;
        if (i_mode_interleaved) begin
            is_result = pos[0];
            pair_j    = pos >> 1;
        end else begin
            is_result = (pos >= eff_half);
            pair_j    = pos - eff_half;
        end
        row_end = (pair_j == eff_half - CNT_W'(1));
        wr_en   = accept && !i_mode_interleaved && !is_result;
        rd_en   = accept && !i_mode_interleaved && is_result;
        n_count = (is_result && row_end) ? '0 : pos + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pending_x <= '0;
            r_v1        <= 1'b0;
        end else begin
            if (i_restart) begin
                r_count     <= '0;
                r_pending_x <= '0;
            end else if (accept) begin
                r_count <= n_count;
                if (i_mode_interleaved && !pos[0]) begin
                    r_pending_x <= i_in.x_value;
                end
            end
            if (i_in.ready) begin
                r_v1 <= accept && is_result;
            end
        end
    end

    // Stage one payload
    always_ff @(posedge i_clk) begin
        if (accept && is_result) begin
            r_ctl1.pair_index <= PAIR_IDX_W'(pair_j);
            r_ctl1.row_done   <= row_end;
            r_ctl1.use_mem    <= !i_mode_interleaved;
            r_x0              <= r_pending_x;
            r_x1              <= i_in.x_value;
            r_cos             <= i_in.cos_value;
            r_sin             <= i_in.sin_value;
        end
    end

    // First-half store: an entry is always written earlier in the row than it is read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[pos[AW-1:0]] <= {i_in.x_value, i_in.cos_value, i_in.sin_value};
        end
        if (rd_en) begin
            r_mem_q <= r_mem[pair_j[AW-1:0]];
        end
    end

    assign o_v1  = r_v1;
    assign o_ctl = r_ctl1;
    assign o_x1  = r_x1;
    assign o_x0  = r_ctl1.use_mem ? r_mem_q[MW-1 -: SAMPLE_BITS] : r_x0;
    assign o_cos = r_ctl1.use_mem ? r_mem_q[2*COEF_W-1 -: COEF_W] : r_cos;
    assign o_sin = r_ctl1.use_mem ? r_mem_q[COEF_W-1:0] : r_sin;

    a_count_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} < row_len)
        else $error("element count beyond the row");

    a_row_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && is_result && row_end |=> r_count == '0)
        else $error("row did not restart after its last pair");

    a_stage1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !i_rdy1 |=> r_v1 && $stable(r_ctl1))
        else $error("stalled pair lost in stage one");

endmodule

`default_nettype wire

// ===== src/rpe_rotate.sv =====
// Pair rotator: four products, rounded sums, saturation and the output register.
`default_nettype none

module rpe_rotate #(
    parameter int SAMPLE_BITS = rpe_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_v1,
    input  wire rpe_pkg::t_pair_ctl                i_ctl,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_x0,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_x1,
    input  wire logic signed [rpe_pkg::COEF_W-1:0] i_cos,
    input  wire logic signed [rpe_pkg::COEF_W-1:0] i_sin,
    output logic                                   o_rdy1,
    rpe_out_if.source                              o_out
);
    import rpe_pkg::*;

    localparam int PW    = SAMPLE_BITS + COEF_W;
    localparam int ACC_W = PW + 1;
    localparam int SH_W  = ACC_W - FRAC_BITS;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                 rdy2;
    logic                 r_v2;
    t_pair_ctl            r_ctl2;
    logic signed [PW-1:0] r_p_xc, r_p_ys, r_p_xs, r_p_yc;

    logic signed [ACC_W-1:0]  acc_first, acc_second;
    logic [SH_W-1:0]          sh_first, sh_second;
    logic [SAMPLE_BITS-1:0]   sat_first, sat_second;

    logic                          r_vo;
    logic signed [SAMPLE_BITS-1:0] r_y_first, r_y_second;
    logic [PAIR_IDX_W-1:0]         r_pair_index;
    logic                          r_row_done;

    assign rdy2   = !r_vo || o_out.ready;
    assign o_rdy1 = !r_v2 || rdy2;

    // Stage two: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (o_rdy1) begin
            r_v2 <= i_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy1 && i_v1) begin
            r_ctl2 <= i_ctl;
            r_p_xc <= PW'(i_x0 * i_cos);
            r_p_ys <= PW'(i_x1 * i_sin);
            r_p_xs <= PW'(i_x0 * i_sin);
            r_p_yc <= PW'(i_x1 * i_cos);
        end
    end

    // Round half up, drop the fraction, clamp to the sample range
    always_comb begin
        acc_first  = ACC_W'(r_p_xc) - ACC_W'(r_p_ys) + RND;
        acc_second = ACC_W'(r_p_xs) + ACC_W'(r_p_yc) + RND;
        sh_first   = acc_first[ACC_W-1:FRAC_BITS];
        sh_second  = acc_second[ACC_W-1:FRAC_BITS];
        if (sh_first[SH_W-1:SAMPLE_BITS-1] == '0 || sh_first[SH_W-1:SAMPLE_BITS-1] == '1) begin
            sat_first = sh_first[SAMPLE_BITS-1:0];
        end else begin
            sat_first = sh_first[SH_W-1] ? SAT_LO : SAT_HI;
        end
        if (sh_second[SH_W-1:SAMPLE_BITS-1] == '0
                || sh_second[SH_W-1:SAMPLE_BITS-1] == '1) begin
            sat_second = sh_second[SAMPLE_BITS-1:0];
        end else begin
            sat_second = sh_second[SH_W-1] ? SAT_LO : SAT_HI;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (rdy2) begin
            r_vo <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v2) begin
            r_y_first    <= sat_first;
            r_y_second   <= sat_second;
            r_pair_index <= r_ctl2.pair_index;
            r_row_done   <= r_ctl2.row_done;
        end
    end

    assign o_out.valid      = r_vo;
    assign o_out.y_first    = r_y_first;
    assign o_out.y_second   = r_y_second;
    assign o_out.pair_index = r_pair_index;
    assign o_out.row_done   = r_row_done;

    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !rdy2 |=> r_v2 && $stable(r_p_xc) && $stable(r_ctl2))
        else $error("stalled products lost in stage two");

    a_out_from_stage2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_vo) |-> $past(r_v2))
        else $error("output beat without a pair in stage two");

endmodule

`default_nettype wire

// ===== src/rotary_position_embed_top.sv =====
// Top level of the rotary position embedding block: configuration and stage wiring.
//
// Usage:
//   Input channel i_in carries one row element (x_value) with the cosine and sine
//   of its pair position. Output channel o_out carries one rotated pair per beat:
//   y_first, y_second, the pair number and a flag on the last pair of the row.
//   Interleaved mode pairs adjacent elements and rotates by the coefficients of
//   the second one; half-split mode keeps the first half of the row with its
//   coefficients in an on-chip store and pairs it with the second half.
//   Configuration (mode, pairs per row) goes through i_cfg_we / i_cfg_idx /
//   i_cfg_data while the block is idle; every write restarts the row.
// Timing:
//   One element is accepted per cycle unless a stalled receiver has filled every
//   stage. After its second element, a pair passes the store read or pair register,
//   the product stage, then the rounding and saturation into the output register.
// Reset clears the element count, the held element, the pipeline and the
// registers (half-split mode, 64 pairs); the store needs no clearing.
// When the receiver stalls, the output register holds its beat and the stages
// behind it keep filling; input ready drops only once all of them are full.
`default_nettype none

module rotary_position_embed_top #(
    parameter int MAX_HALF_DIM = rpe_pkg::DEF_MAX_HALF_DIM,
    parameter int SAMPLE_BITS  = rpe_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire rpe_pkg::t_cfg_idx         i_cfg_idx,
    input  wire logic [rpe_pkg::CFG_W-1:0] i_cfg_data,
    rpe_in_if.sink                         i_in,
    rpe_out_if.source                      o_out
);
    import rpe_pkg::*;

    logic                          r_mode_interleaved;
    logic [CFG_W-1:0]              r_half_dim;
    logic                          restart;

    logic                          v1;
    logic                          rdy1;
    t_pair_ctl                     ctl1;
    logic signed [SAMPLE_BITS-1:0] x0, x1;
    logic signed [COEF_W-1:0]      cos1, sin1;

    always_comb begin
        restart = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE_INTERLEAVED: restart = 1'b1;
                REG_HALF_DIM:         restart = 1'b1;
                default:              restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_interleaved <= 1'b0;
            r_half_dim         <= HALF_DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE_INTERLEAVED: r_mode_interleaved <= i_cfg_data[0];
                REG_HALF_DIM:         r_half_dim         <= i_cfg_data;
                default: begin
                    r_mode_interleaved <= r_mode_interleaved;
                end
            endcase
        end
    end

    rpe_front #(
        .MAX_HALF_DIM (MAX_HALF_DIM),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_mode_interleaved (r_mode_interleaved),
        .i_half_dim         (r_half_dim),
        .i_restart          (restart),
        .i_in               (i_in),
        .i_rdy1             (rdy1),
        .o_v1               (v1),
        .o_ctl              (ctl1),
        .o_x0               (x0),
        .o_x1               (x1),
        .o_cos              (cos1),
        .o_sin              (sin1)
    );

    rpe_rotate #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v1    (v1),
        .i_ctl   (ctl1),
        .i_x0    (x0),
        .i_x1    (x1),
        .i_cos   (cos1),
        .i_sin   (sin1),
        .o_rdy1  (rdy1),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== verif/rotary_position_embed_top_tb.sv =====
// Testbench for the rotary position embedding top: random rows against a pair predictor.
`timescale 1ns / 100ps

module rotary_position_embed_top_tb;
    import rpe_pkg::*;

    localparam int ITEM_TARGET   = 850;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 150;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PRINT_CAP     = 40;
    localparam int STORE_DEPTH   = DEF_MAX_HALF_DIM;
    localparam longint SAMPLE_MAX = (64'sd1 <<< (DEF_SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    typedef logic signed [DEF_SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]          t_coef;

    typedef struct {
        t_sample               y_first;
        t_sample               y_second;
        logic [PAIR_IDX_W-1:0] pair_index;
        logic                  row_done;
    } t_rotated_pair;

    class rotation_predictor;
        bit                 interleaved;
        logic [CFG_W-1:0]   half_reg;
        int unsigned        elem_pos;
        t_sample            held_x;
        t_sample            store_x[STORE_DEPTH];
        t_coef              store_cos[STORE_DEPTH];
        t_coef              store_sin[STORE_DEPTH];
        t_rotated_pair      expected_pairs[$];
        int                 mismatches;

        function new();
            interleaved = 1'b0;
            half_reg    = HALF_DIM_RESET;
            elem_pos    = 0;
            held_x      = '0;
            mismatches  = 0;
        endfunction

        // Any register write restarts the row and drops a held element.
        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_MODE_INTERLEAVED: interleaved = value[0];
                REG_HALF_DIM:         half_reg = value;
                default:              return;
            endcase
            elem_pos = 0;
            held_x   = '0;
        endfunction

        function int unsigned pairs_per_row();
            if (half_reg == 0) return 1;
            if (half_reg > STORE_DEPTH) return STORE_DEPTH;
            return half_reg;
        endfunction

        // Add half an LSB, shift down to the sample grid (floor), then clamp.
        function t_sample round_saturate(longint acc);
            longint r;
            r = (acc + 64'sd16384) >>> FRAC_BITS;
            if (r > SAMPLE_MAX) r = SAMPLE_MAX;
            if (r < SAMPLE_MIN) r = SAMPLE_MIN;
            return t_sample'(r);
        endfunction

        function void note_element(t_sample x, t_coef c, t_coef s);
            int unsigned   half;
            int unsigned   pos;
            int unsigned   j;
            longint        x0;
            longint        x1;
            longint        cv;
            longint        sv;
            t_rotated_pair p;
            half = pairs_per_row();
            pos  = elem_pos;
            if (pos >= 2 * half) pos = 0;
            elem_pos = pos + 1;
            if (interleaved) begin
                if (pos[0] == 1'b0) begin
                    held_x = x;
                    return;
                end
                j  = pos >> 1;
                x0 = held_x;
                cv = c;
                sv = s;
            end else begin
                if (pos < half) begin
                    store_x[pos]   = x;
                    store_cos[pos] = c;
                    store_sin[pos] = s;
                    return;
                end
                // second-half coefficients are ignored
                j  = pos - half;
                x0 = store_x[j];
                cv = store_cos[j];
                sv = store_sin[j];
            end
            x1 = x;
            p.y_first    = round_saturate(x0 * cv - x1 * sv);
            p.y_second   = round_saturate(x0 * sv + x1 * cv);
            p.pair_index = j[PAIR_IDX_W-1:0];
            p.row_done   = (j + 1 == half);
            if (p.row_done) elem_pos = 0;
            expected_pairs.push_back(p);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_pair(t_rotated_pair got);
            t_rotated_pair want;
            if (expected_pairs.size() == 0) begin
                report_mismatch($sformatf("unexpected pair %0d: %0d %0d", got.pair_index,
                                          got.y_first, got.y_second));
                return;
            end
            want = expected_pairs.pop_front();
            if (got.y_first !== want.y_first)
                report_mismatch($sformatf("pair %0d y_first %0d, want %0d", want.pair_index,
                                          got.y_first, want.y_first));
            if (got.y_second !== want.y_second)
                report_mismatch($sformatf("pair %0d y_second %0d, want %0d", want.pair_index,
                                          got.y_second, want.y_second));
            if (got.pair_index !== want.pair_index)
                report_mismatch($sformatf("pair_index %0d, want %0d", got.pair_index,
                                          want.pair_index));
            if (got.row_done !== want.row_done)
                report_mismatch($sformatf("pair %0d row_done %b, want %b", want.pair_index,
                                          got.row_done, want.row_done));
        endtask

        task report_leftovers();
            if (expected_pairs.size() != 0)
                report_mismatch($sformatf("%0d expected pairs never arrived",
                                          expected_pairs.size()));
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    t_cfg_idx         i_cfg_idx = REG_MODE_INTERLEAVED;
    logic [CFG_W-1:0] i_cfg_data = '0;

    rpe_in_if  elem_ch ();
    rpe_out_if pair_ch ();

    rotation_predictor rotator;
    bit idle_on = 1'b1;
    bit sink_hold_pending = 1'b0;
    int quiet_cycles = 0;

    rotary_position_embed_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (elem_ch),
        .o_out      (pair_ch)
    );

    always #4 i_clk = ~i_clk;

    // Biased towards the ends of the range and the all-zero / all-one words.
    function automatic t_sample pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return '1;
            default: return t_sample'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_element(t_sample x, t_coef c, t_coef s);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            elem_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        elem_ch.x_value   <= x;
        elem_ch.cos_value <= c;
        elem_ch.sin_value <= s;
        elem_ch.valid     <= 1'b1;
        do @(posedge i_clk); while (elem_ch.ready !== 1'b1);
        rotator.note_element(x, c, s);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        rotator.write_reg(idx, value);
        @(negedge i_clk);
    endtask

    task automatic configure(bit wr_mode, bit wr_half, bit mode, logic [CFG_W-1:0] half);
        logic [CFG_W-2:0] pad;
        pad = (CFG_W-1)'($urandom_range(0, 63));
        if (wr_mode) write_reg(REG_MODE_INTERLEAVED, {pad, mode});
        if (wr_half) write_reg(REG_HALF_DIM, half);
        i_cfg_we <= 1'b0;
    endtask

    // Drain every expected pair, then let the store write of a trailing element finish.
    task automatic settle_block();
        elem_ch.valid <= 1'b0;
        while (rotator.expected_pairs.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (elem_ch.valid && elem_ch.ready) || (pair_ch.valid && pair_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("rotary_position_embed_top_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : pair_sink
        int            stall;
        t_rotated_pair got;
        pair_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 10) : 0;
            if (sink_hold_pending) begin
                stall = LONG_HOLD;
                sink_hold_pending = 1'b0;
            end
            if (stall > 0) begin
                pair_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pair_ch.ready <= 1'b1;
            do @(posedge i_clk); while (pair_ch.valid !== 1'b1);
            got.y_first    = pair_ch.y_first;
            got.y_second   = pair_ch.y_second;
            got.pair_index = pair_ch.pair_index;
            got.row_done   = pair_ch.row_done;
            rotator.check_pair(got);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int               sent;
        int               phase;
        int               rows;
        int               tail;
        int               eff;
        int               n;
        int               sel;
        bit               wr_mode;
        bit               wr_half;
        bit               mode;
        logic [CFG_W-1:0] half;
        rotator = new();
        elem_ch.valid     = 1'b0;
        elem_ch.x_value   = '0;
        elem_ch.cos_value = '0;
        elem_ch.sin_value = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Interleaved, two pairs per row: saturation both ways, rounding, zeros.
        configure(1'b1, 1'b1, 1'b1, 7'd2);
        send_element(16'sh7FFF, 16'sh8000, 16'sh8000);
        send_element(16'sh8000, 16'sh8000, 16'sh8000);
        send_element(16'sh8000, 16'sh0000, 16'sh0000);
        send_element(16'sh8000, 16'sh8000, 16'sh7FFF);
        send_element(16'sh0000, 16'sh0000, 16'sh0000);
        send_element(16'sh0001, 16'sh4000, 16'sh4000);
        send_element(16'shFFFF, 16'sh7FFF, 16'sh7FFF);
        send_element(16'sh7FFF, 16'sh7FFF, 16'sh8000);
        // leave an element held; the next register write must drop it
        send_element(16'sh007B, 16'sh1234, 16'shEDCB);
        settle_block();

        // Half-split with zero pairs per row, which acts as one pair.
        configure(1'b1, 1'b1, 1'b0, 7'd0);
        send_element(16'sh8000, 16'sh7FFF, 16'sh8000);
        send_element(16'sh7FFF, 16'shFFFF, 16'sh0000);
        send_element(16'shFFFF, 16'sh8000, 16'sh8000);
        send_element(16'shFFFF, 16'sh0005, 16'sh0005);
        settle_block();

        // Half-split, three pairs, then a partial row.
        configure(1'b0, 1'b1, 1'b0, 7'd3);
        repeat (8) send_element(pick_word(), pick_word(), pick_word());
        sent  = 21;
        phase = 0;

        while (sent < ITEM_TARGET) begin
            settle_block();
            idle_on = ($urandom_range(0, 3) != 0);
            wr_mode = 1'b1;
            wr_half = 1'b1;
            mode    = 1'($urandom_range(0, 1));
            case (phase)
                0: begin
                    mode = 1'b0;
                    half = 7'd64;
                end
                1: begin
                    mode = 1'b1;
                    half = CFG_W'($urandom_range(65, 127));
                end
                2: begin
                    // block fills while the receiver holds off
                    mode    = 1'b1;
                    half    = 7'd4;
                    idle_on = 1'b0;
                end
                default: begin
                    sel = $urandom_range(0, 19);
                    if (sel == 0)      half = 7'd0;
                    else if (sel == 1) half = 7'd64;
                    else if (sel == 2) half = CFG_W'($urandom_range(65, 127));
                    else if (sel < 7)  half = CFG_W'($urandom_range(9, 63));
                    else               half = CFG_W'($urandom_range(1, 8));
                    sel = $urandom_range(0, 3);
                    if (sel == 0) wr_half = 1'b0;
                    if (sel == 1) wr_mode = 1'b0;
                end
            endcase
            configure(wr_mode, wr_half, mode, half);
            eff = rotator.pairs_per_row();
            if (phase == 2) begin
                sink_hold_pending = 1'b1;
                n = 80;
            end else begin
                rows = (eff > 16) ? 1 : $urandom_range(1, 4);
                tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * eff - 1) : 0;
                n    = rows * 2 * eff + tail;
            end
            repeat (n) send_element(pick_word(), pick_word(), pick_word());
            sent  += n;
            phase += 1;
        end

        settle_block();
        rotator.report_leftovers();
        if (rotator.mismatches == 0) begin
            $display("rotary_position_embed_top_tb: done, clean");
        end else begin
            $display("rotary_position_embed_top_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/rpe_pkg.sv
src/rpe_in_if.sv
src/rpe_out_if.sv
src/rpe_front.sv
src/rpe_rotate.sv
src/rotary_position_embed_top.sv
verif/rotary_position_embed_top_tb.sv
